[design/vptw_pkg.sv]
// shared types, constants and helpers for the vertex projection pipeline
// no dependencies; used by every module of vertex_project_to_window
package vptw_pkg;

  localparam int CW = 32;             // coordinate and matrix entry width
  localparam int FB = 16;             // fraction bits of the Q16.16 format
  localparam int NUM_W = CW + FB;     // width of the scaled divide numerator
  localparam logic [CW-1:0] ONE = CW'(64'd1 << FB);

  // item kinds carried in the mode field
  localparam logic [1:0] MODE_MODEL = 2'd0;
  localparam logic [1:0] MODE_PROJ  = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_VX = 2'd0;
  localparam logic [1:0] REG_VY = 2'd1;
  localparam logic [1:0] REG_VW = 2'd2;
  localparam logic [1:0] REG_VH = 2'd3;

  localparam logic [15:0] VW_RESET = 16'd640;
  localparam logic [15:0] VH_RESET = 16'd480;

  // one item as it moves through the two matrix stages
  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         idx;
    logic [CW-1:0]      value;
    logic [3:0][CW-1:0] vec;
  } item_t;

  // divider result handed to the viewport stage
  typedef struct packed {
    logic               ok;
    logic [2:0][CW-1:0] n;
  } div_out_t;

  // identity matrix, entries on the diagonal are one
  function automatic logic [15:0][CW-1:0] identity();
    logic [15:0][CW-1:0] m;
    for (int i = 0; i < 16; i++) begin
      m[i] = (i % 5 == 0) ? ONE : '0;
    end
    return m;
  endfunction

  // saturate a signed value to CW bits
  function automatic logic [CW-1:0] sat_cw(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

endpackage

[design/vptw_matvec.sv]
// one 4x4 matrix times vector stage: stored matrix, products, sum and saturation
// depends on vptw_pkg
module vptw_matvec #(
  parameter logic [1:0] LOAD_MODE = vptw_pkg::MODE_MODEL
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vptw_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output vptw_pkg::item_t out_item
);
  import vptw_pkg::*;

  logic [15:0][CW-1:0] mat;
  logic v1, v2, en1, en2;
  item_t item1;
  logic signed [NUM_W-1:0] prod [16];
  logic signed [63:0] prod_c [16];
  logic signed [NUM_W+1:0] sum_c [4];
  item_t item2_c;

  // stall chain: a stage moves when the one after it has room
  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v2;

  // valid bits and matrix loads, loads take effect in item order
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      mat <= identity();
    end else begin
      if (en1) begin
        v1 <= in_valid;
        if (in_valid && in_item.mode == LOAD_MODE) begin
          mat[in_item.idx] <= in_item.value;
        end
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  // sixteen products, entry 4*column+row times vector element column
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        prod_c[4*k+j] = $signed(mat[4*k+j]) * $signed(in_item.vec[k]);
      end
    end
  end

  // product register, floor shift by the fraction bits
  always_ff @(posedge clk) begin
    if (en1) begin
      item1 <= in_item;
      for (int i = 0; i < 16; i++) begin
        prod[i] <= prod_c[i][FB+NUM_W-1:FB];
      end
    end
  end

  // row sums with saturation
  always_comb begin
    item2_c = item1;
    for (int j = 0; j < 4; j++) begin
      sum_c[j] = (NUM_W+2)'(prod[j]) + (NUM_W+2)'(prod[4+j])
               + (NUM_W+2)'(prod[8+j]) + (NUM_W+2)'(prod[12+j]);
      item2_c.vec[j] = sat_cw(64'(sum_c[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_item <= item2_c;
    end
  end

endmodule

[design/vptw_div.sv]
// perspective divide: three lanes of restoring division by clip w, one bit per stage
// depends on vptw_pkg
module vptw_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0][vptw_pkg::CW-1:0] in_clip,
  output logic               out_valid,
  input  logic               out_ready,
  output vptw_pkg::div_out_t out_res
);
  import vptw_pkg::*;

  localparam int RQ_W = CW + NUM_W;
  localparam int LAST = NUM_W + 1;

  typedef struct packed {
    logic                 ok;
    logic [2:0]           neg;
    logic [CW-1:0]        den;
    logic [2:0][RQ_W-1:0] rq;
  } dstage_t;

  dstage_t st [0:NUM_W];
  dstage_t prep_c;
  logic v  [0:LAST];
  logic en [0:LAST];
  div_out_t res_c;

  // stall chain through every stage
  assign en[LAST] = !v[LAST] || out_ready;
  genvar g;
  generate
    for (g = 0; g < LAST; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate
  assign in_ready = en[0];
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) v[i] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // signs and magnitudes, numerator scaled by one
  always_comb begin
    logic [CW-1:0] mag;
    prep_c.ok  = (in_clip[3] != '0);
    prep_c.den = in_clip[3][CW-1] ? (~in_clip[3] + 1'b1) : in_clip[3];
    for (int i = 0; i < 3; i++) begin
      mag = in_clip[i][CW-1] ? (~in_clip[i] + 1'b1) : in_clip[i];
      prep_c.neg[i] = in_clip[i][CW-1] ^ in_clip[3][CW-1];
      prep_c.rq[i]  = {{CW{1'b0}}, mag, {FB{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st[0] <= prep_c;
  end

  // one quotient bit per stage in each lane
  generate
    for (g = 1; g <= NUM_W; g++) begin : g_step
      dstage_t step_c;
      always_comb begin
        logic [RQ_W:0] sh;
        logic [CW:0]   top;
        step_c = st[g-1];
        for (int i = 0; i < 3; i++) begin
          sh  = {st[g-1].rq[i], 1'b0};
          top = sh[RQ_W:NUM_W];
          if (top >= {1'b0, st[g-1].den}) begin
            top = top - {1'b0, st[g-1].den};
            sh[0] = 1'b1;
          end
          step_c.rq[i] = {top[CW-1:0], sh[NUM_W-1:0]};
        end
      end
      always_ff @(posedge clk) begin
        if (en[g]) st[g] <= step_c;
      end
    end
  endgenerate

  // apply sign and saturate the quotient
  always_comb begin
    logic [NUM_W-1:0] q;
    res_c.ok = st[NUM_W].ok;
    for (int i = 0; i < 3; i++) begin
      q = st[NUM_W].rq[i][NUM_W-1:0];
      if (st[NUM_W].neg[i]) begin
        if (q > (NUM_W'(1) << (CW - 1))) res_c.n[i] = {1'b1, {(CW-1){1'b0}}};
        else res_c.n[i] = ~q[CW-1:0] + 1'b1;
      end else begin
        if (q > ((NUM_W'(1) << (CW - 1)) - 1'b1)) res_c.n[i] = {1'b0, {(CW-1){1'b1}}};
        else res_c.n[i] = q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) out_res <= res_c;
  end

endmodule

[design/vptw_viewport.sv]
// viewport and depth mapping of normalized coordinates, two register stages
// depends on vptw_pkg
module vptw_viewport (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vptw_pkg::div_out_t in_res,
  input  logic [15:0]        viewport_x,
  input  logic [15:0]        viewport_y,
  input  logic [15:0]        viewport_width,
  input  logic [15:0]        viewport_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0][vptw_pkg::CW-1:0] out_win,
  output logic               out_ok
);
  import vptw_pkg::*;

  logic v1, v2, en1, en2;
  logic ok1;
  logic signed [CW+17:0] px, py, px_c, py_c;
  logic signed [CW:0] dz, nx1, ny1, nz1;
  logic signed [63:0] wx_c, wy_c;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // shift to the zero..two range and scale by the viewport size
  always_comb begin
    nx1  = $signed({in_res.n[0][CW-1], in_res.n[0]}) + $signed({1'b0, ONE});
    ny1  = $signed({in_res.n[1][CW-1], in_res.n[1]}) + $signed({1'b0, ONE});
    nz1  = $signed({in_res.n[2][CW-1], in_res.n[2]}) + $signed({1'b0, ONE});
    px_c = $signed({1'b0, viewport_width}) * nx1;
    py_c = $signed({1'b0, viewport_height}) * ny1;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1 <= in_res.ok;
      px  <= px_c;
      py  <= py_c;
      dz  <= nz1;
    end
  end

  // halve, add the viewport origin, saturate
  always_comb begin
    wx_c = 64'($signed({viewport_x, {FB{1'b0}}})) + 64'(px >>> 1);
    wy_c = 64'($signed({viewport_y, {FB{1'b0}}})) + 64'(py >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_ok <= ok1;
      if (ok1) begin
        out_win[0] <= sat_cw(wx_c);
        out_win[1] <= sat_cw(wy_c);
        out_win[2] <= sat_cw(64'(dz >>> 1));
      end else begin
        out_win <= '0;
      end
    end
  end

endmodule

[design/vertex_project_to_window.sv]
// vertex projection top level: input and output streams, viewport registers
// depends on vptw_pkg, vptw_matvec, vptw_div, vptw_viewport
//
// Takes one item per clock with no gaps, whatever the mix of matrix loads and points,
// unless the output stalls. A point passes through two stages for the model matrix
// product, two for the projection product, 50 for the perspective divide (one
// quotient bit per stage over the 48-bit scaled numerator, plus setup and saturation)
// and two for the viewport mapping. Matrix loads travel down the same pipeline and
// update their matrix at the stage that uses it, so they take effect exactly in item
// order; they and mode 3 items give no result. Stalls on the output back up stage by
// stage and empty stages keep filling. The user must write the viewport registers
// through the APB port only while the block is idle; the block does not enforce this.
module vertex_project_to_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,  // entry_index, entry_value, point_x, point_y, point_z, pad
  input  logic [1:0]    s_tuser,  // mode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [95:0]   m_tdata,  // win_x, win_y, win_depth
  output logic [0:0]    m_tuser,  // ok
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import vptw_pkg::*;

  logic [15:0] viewport_x, viewport_y, viewport_width, viewport_height;
  item_t in_item, mid_item, clip_item;
  logic mid_valid, mid_ready, clip_valid, clip_ready;
  logic div_in_ready, div_valid, div_ready;
  div_out_t div_res;
  logic [2:0][CW-1:0] win;
  logic is_point;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_x      <= '0;
      viewport_y      <= '0;
      viewport_width  <= VW_RESET;
      viewport_height <= VH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_VX: viewport_x      <= pwdata[15:0];
        REG_VY: viewport_y      <= pwdata[15:0];
        REG_VW: viewport_width  <= pwdata[15:0];
        REG_VH: viewport_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VX:  prdata = {{16{viewport_x[15]}}, viewport_x};
      REG_VY:  prdata = {{16{viewport_y[15]}}, viewport_y};
      REG_VW:  prdata = {16'b0, viewport_width};
      REG_VH:  prdata = {16'b0, viewport_height};
      default: prdata = '0;
    endcase
  end

  // unpack the input item, w of the object point is one
  always_comb begin
    in_item.mode   = s_tuser;
    in_item.idx    = s_tdata[3:0];
    in_item.value  = s_tdata[35:4];
    in_item.vec[0] = s_tdata[67:36];
    in_item.vec[1] = s_tdata[99:68];
    in_item.vec[2] = s_tdata[131:100];
    in_item.vec[3] = ONE;
  end

  vptw_matvec #(.LOAD_MODE(MODE_MODEL)) u_model (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(mid_valid), .out_ready(mid_ready), .out_item(mid_item)
  );

  vptw_matvec #(.LOAD_MODE(MODE_PROJ)) u_proj (
    .clk, .rst,
    .in_valid(mid_valid), .in_ready(mid_ready), .in_item(mid_item),
    .out_valid(clip_valid), .out_ready(clip_ready), .out_item(clip_item)
  );

  // only points go on to the divide, everything else is dropped here
  assign is_point   = (clip_item.mode == MODE_POINT);
  assign clip_ready = div_in_ready || !is_point;

  vptw_div u_div (
    .clk, .rst,
    .in_valid(clip_valid && is_point), .in_ready(div_in_ready), .in_clip(clip_item.vec),
    .out_valid(div_valid), .out_ready(div_ready), .out_res(div_res)
  );

  vptw_viewport u_vp (
    .clk, .rst,
    .in_valid(div_valid), .in_ready(div_ready), .in_res(div_res),
    .viewport_x, .viewport_y, .viewport_width, .viewport_height,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_win(win), .out_ok(m_tuser[0])
  );

  assign m_tdata = {win[2], win[1], win[0]};

  // a result with a zero clip w carries zero coordinates
  a_zero_on_bad_w: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero coordinates on a result with zero clip w");

  // the input side only stalls when the output is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

endmodule

[sim/testbench.sv]
// self-checking testbench for vertex_project_to_window
// drives item and APB ports, predicts each point result; needs vptw_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
  import vptw_pkg::*;

  // mode value that the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;   // entry_index, entry_value, point_x, point_y, point_z, pad
  logic [1:0]   s_tuser;   // mode
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;   // win_x, win_y, win_depth
  logic [0:0]   m_tuser;   // ok
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  typedef struct {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wd;
    logic        ok;
  } window_t;

  // shadow state of the block
  longint  model_m [16];
  longint  proj_m [16];
  longint  vp_x, vp_y, vp_w, vp_h;
  window_t window_q [$];
  int      errors;
  int      points_sent;
  int      loads_sent;
  int      points_seen;
  bit      quiet;

  vertex_project_to_window dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("vertex_project_to_window verification failed");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // matrix times vector, floor on each product, saturated sum
  function automatic void mat_vec(input longint m [16], input longint v [4],
                                  output longint r [4]);
    longint s;
    for (int j = 0; j < 4; j++) begin
      s = 0;
      for (int k = 0; k < 4; k++) s += (m[4*k+j] * v[k]) >>> FB;
      r[j] = sat32(s);
    end
  endfunction

  // full projection of one point to window coordinates
  function automatic window_t project_point(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz);
    longint  obj [4];
    longint  eye [4];
    longint  clip [4];
    longint  n [3];
    window_t w;
    obj[0] = longint'($signed(px));
    obj[1] = longint'($signed(py));
    obj[2] = longint'($signed(pz));
    obj[3] = 64'sd1 <<< FB;
    mat_vec(model_m, obj, eye);
    mat_vec(proj_m, eye, clip);
    if (clip[3] == 0) begin
      w.wx = '0; w.wy = '0; w.wd = '0; w.ok = 1'b0;
      return w;
    end
    for (int i = 0; i < 3; i++) n[i] = sat32((clip[i] <<< FB) / clip[3]);
    w.wx = 32'(sat32((vp_x <<< FB) + ((vp_w * (n[0] + (64'sd1 <<< FB))) >>> 1)));
    w.wy = 32'(sat32((vp_y <<< FB) + ((vp_h * (n[1] + (64'sd1 <<< FB))) >>> 1)));
    w.wd = 32'(sat32((n[2] + (64'sd1 <<< FB)) >>> 1));
    w.ok = 1'b1;
    return w;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    window_t e;
    if (!rst && m_tvalid && m_tready) begin
      points_seen++;
      if (window_q.size() == 0) begin
        report("unexpected item", m_tdata[31:0], 32'h0);
      end else begin
        e = window_q.pop_front();
        if (m_tdata[31:0] !== e.wx) report("win_x", m_tdata[31:0], e.wx);
        if (m_tdata[63:32] !== e.wy) report("win_y", m_tdata[63:32], e.wy);
        if (m_tdata[95:64] !== e.wd) report("win_depth", m_tdata[95:64], e.wd);
        if (m_tuser[0] !== e.ok) report("ok", 32'(m_tuser), 32'(e.ok));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // send one item; valid is left high so back-to-back items need no gap
  task automatic send_item(logic [1:0] mode, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (!quiet) begin
      while ($urandom_range(99) < 15) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'h0, pz, py, px, val, idx};
    do @(posedge clk); while (!s_tready);
    case (mode)
      MODE_MODEL: begin model_m[idx] = longint'($signed(val)); loads_sent++; end
      MODE_PROJ:  begin proj_m[idx] = longint'($signed(val)); loads_sent++; end
      MODE_POINT: begin window_q.push_back(project_point(px, py, pz)); points_sent++; end
      default: ;
    endcase
  endtask

  // wait until every point result is back, then let the pipeline drain
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (window_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_idx)
      REG_VX: vp_x = longint'($signed(data[15:0]));
      REG_VY: vp_y = longint'($signed(data[15:0]));
      REG_VW: vp_w = longint'(data[15:0]);
      default: vp_h = longint'(data[15:0]);
    endcase
  endtask

  task automatic set_viewport(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                              logic [15:0] h);
    apb_write(REG_VX, {16'($urandom_range(65535)), x});
    apb_write(REG_VY, {16'($urandom_range(65535)), y});
    apb_write(REG_VW, {16'($urandom_range(65535)), w});
    apb_write(REG_VH, {16'($urandom_range(65535)), h});
  endtask

  // coordinates: mostly modest, sometimes full range or an extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  // matrix entries: small weights, with occasional wide or zero values
  function automatic logic [31:0] rand_entry();
    case ($urandom_range(9))
      0: return $urandom();
      1: return '0;
      default: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
    endcase
  endfunction

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_item(MODE_POINT, 4'($urandom()), $urandom(), px, py, pz);
  endtask

  // identity matrices and reset viewport
  task automatic test_reset_state();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();
  endtask

  // loads, unused mode, perspective, zero clip w, overflow
  task automatic test_directed();
    send_item(MODE_UNUSED, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_point(32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    // perspective: w takes minus z
    send_item(MODE_PROJ, 4'd11, 32'hffff_0000, 32'h0, 32'h0, 32'h0);
    send_item(MODE_PROJ, 4'd15, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    // zero clip w
    send_point(32'h0005_0000, 32'h0006_0000, 32'h0);
    // wide model entries drive saturation
    send_item(MODE_MODEL, 4'd0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    send_item(MODE_MODEL, 4'd5, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_item(MODE_MODEL, 4'd14, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(MODE_UNUSED, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
    drain();
  endtask

  // viewport extremes with a fixed perspective setup
  task automatic test_viewport();
    for (int i = 0; i < 16; i++) begin
      send_item(MODE_MODEL, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0, '0, '0, '0);
      send_item(MODE_PROJ, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0, '0, '0, '0);
    end
    send_item(MODE_PROJ, 4'd11, 32'hffff_0000, '0, '0, '0);
    send_item(MODE_PROJ, 4'd15, 32'h0, '0, '0, '0);
    drain();
    set_viewport(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    set_viewport(16'h7fff, 16'h8000, 16'h0000, 16'hffff);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // random mix of loads and points over several viewports
  task automatic test_random();
    int   r;
    for (int phase = 0; phase < 4; phase++) begin
      set_viewport(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      quiet = (phase == 1);
      for (int i = 0; i < 105; i++) begin
        r = $urandom_range(99);
        if (r < 55) send_point(rand_coord(), rand_coord(), rand_coord());
        else if (r < 75)
          send_item(MODE_MODEL, 4'($urandom()), rand_entry(), $urandom(), $urandom(),
                    $urandom());
        else if (r < 95)
          send_item(MODE_PROJ, 4'($urandom()), rand_entry(), $urandom(), $urandom(),
                    $urandom());
        else
          send_item(MODE_UNUSED, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom());
        // hold the sender until every result is back
        if (phase == 2 && i == 50) drain();
      end
      drain();
      quiet = 1'b0;
    end
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; points_sent = 0; loads_sent = 0; points_seen = 0;
    for (int i = 0; i < 16; i++) begin
      model_m[i] = (i % 5 == 0) ? 64'sd65536 : 0;
      proj_m[i]  = (i % 5 == 0) ? 64'sd65536 : 0;
    end
    vp_x = 0; vp_y = 0; vp_w = 640; vp_h = 480;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed();
    test_viewport();
    test_random();

    $display("covered %0d points and %0d matrix loads, %0d results checked", points_sent,
             loads_sent, points_seen);
    $display("viewport extremes, zero clip w, saturation and unused mode exercised");
    if (errors == 0) begin
      $display("vertex_project_to_window verification clean");
    end else begin
      $display("vertex_project_to_window verification failed");
    end
    $finish;
  end

endmodule
